FILE: rtl/core/lesm_pkg.sv
`default_nettype none

package lesm_pkg;

    localparam int NUM_STATES = 15;
    localparam int STATE_W    = 4;
    localparam int EVENT_W    = 5;
    localparam int TICK_W     = 32;
    localparam int CNT_W      = 32;
    localparam int BIN_W      = 48;

    typedef enum logic [STATE_W-1:0] {
        ST_UNINITIALIZED  = 4'd0,
        ST_INITIALIZING   = 4'd1,
        ST_MODEL_LOADING  = 4'd2,
        ST_READY          = 4'd3,
        ST_PREFETCHING    = 4'd4,
        ST_COMPUTING      = 4'd5,
        ST_SAMPLING       = 4'd6,
        ST_STREAMING      = 4'd7,
        ST_COOLDOWN       = 4'd8,
        ST_DRAINING       = 4'd9,
        ST_SHUTTING_DOWN  = 4'd10,
        ST_SHUTDOWN       = 4'd11,
        ST_FAULTED        = 4'd12,
        ST_HOTPATCH       = 4'd13,
        ST_RECOVERING     = 4'd14
    } lesm_state_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_INITIALIZE         = 5'd0,
        EV_MODEL_LOADED       = 5'd1,
        EV_REQUEST_RECEIVED   = 5'd2,
        EV_PREFETCH_DONE      = 5'd3,
        EV_LAYER_COMPUTED     = 5'd4,
        EV_FORWARD_DONE       = 5'd5,
        EV_TOKEN_SAMPLED      = 5'd6,
        EV_TOKEN_STREAMED     = 5'd7,
        EV_GENERATION_DONE    = 5'd8,
        EV_COOLDOWN_DONE      = 5'd9,
        EV_DRAIN_REQUESTED    = 5'd10,
        EV_DRAIN_COMPLETE     = 5'd11,
        EV_SHUTDOWN_DONE      = 5'd12,
        EV_FAULT_DETECTED     = 5'd13,
        EV_RECOVERY_DONE      = 5'd14,
        EV_HOTPATCH_REQUEST   = 5'd15,
        EV_HOTPATCH_APPLIED   = 5'd16,
        EV_RESET              = 5'd17
    } lesm_event_t;

    typedef enum logic {
        REQ_EVENT = 1'b0,
        REQ_FORCE = 1'b1
    } lesm_req_kind_t;

    typedef struct packed {
        logic                req_type;
        logic [EVENT_W-1:0]  event_code;
        logic [STATE_W-1:0]  forced_state;
        logic [TICK_W-1:0]   now_ticks;
    } req_item_t;

    typedef struct packed {
        logic                accepted;
        logic [STATE_W-1:0]  old_state;
        logic [STATE_W-1:0]  new_state;
        logic [TICK_W-1:0]   residency_ticks;
        logic [CNT_W-1:0]    sequence_number;
        logic [CNT_W-1:0]    total_count;
        logic [CNT_W-1:0]    rejected_count;
        logic [CNT_W-1:0]    fault_count;
        logic [CNT_W-1:0]    recovery_count;
        logic [CNT_W-1:0]    hotpatch_count;
        logic [TICK_W-1:0]   max_residency;
        logic [BIN_W-1:0]    old_state_total;
    } rsp_item_t;

    // Read request into the bin store, with the amount to add once the data returns.
    typedef struct packed {
        logic                en;
        logic [STATE_W-1:0]  addr;
        logic                add_en;
        logic [TICK_W-1:0]   add_val;
    } bin_req_t;

    typedef struct packed {
        logic        hit;
        lesm_state_t to;
    } rule_res_t;

    function automatic rule_res_t rule_lookup(lesm_state_t st, logic [EVENT_W-1:0] ev);
        rule_res_t r;
        r.hit = 1'b1;
        r.to  = st;
        unique case ({st, ev})
            {ST_UNINITIALIZED, EV_INITIALIZE}:       r.to = ST_INITIALIZING;
            {ST_INITIALIZING,  EV_MODEL_LOADED}:     r.to = ST_MODEL_LOADING;
            {ST_MODEL_LOADING, EV_MODEL_LOADED}:     r.to = ST_READY;
            {ST_READY,         EV_REQUEST_RECEIVED}: r.to = ST_PREFETCHING;
            {ST_PREFETCHING,   EV_PREFETCH_DONE}:    r.to = ST_COMPUTING;
            {ST_COMPUTING,     EV_LAYER_COMPUTED}:   r.to = ST_COMPUTING;
            {ST_COMPUTING,     EV_FORWARD_DONE}:     r.to = ST_SAMPLING;
            {ST_SAMPLING,      EV_TOKEN_SAMPLED}:    r.to = ST_STREAMING;
            {ST_STREAMING,     EV_TOKEN_STREAMED}:   r.to = ST_PREFETCHING;
            {ST_STREAMING,     EV_GENERATION_DONE}:  r.to = ST_COOLDOWN;
            {ST_COOLDOWN,      EV_COOLDOWN_DONE}:    r.to = ST_READY;
            {ST_READY,         EV_HOTPATCH_REQUEST}: r.to = ST_HOTPATCH;
            {ST_HOTPATCH,      EV_HOTPATCH_APPLIED}: r.to = ST_READY;
            {ST_COMPUTING,     EV_FAULT_DETECTED}:   r.to = ST_FAULTED;
            {ST_SAMPLING,      EV_FAULT_DETECTED}:   r.to = ST_FAULTED;
            {ST_PREFETCHING,   EV_FAULT_DETECTED}:   r.to = ST_FAULTED;
            {ST_STREAMING,     EV_FAULT_DETECTED}:   r.to = ST_FAULTED;
            {ST_FAULTED,       EV_INITIALIZE}:       r.to = ST_RECOVERING;
            {ST_RECOVERING,    EV_RECOVERY_DONE}:    r.to = ST_READY;
            {ST_READY,         EV_DRAIN_REQUESTED}:  r.to = ST_DRAINING;
            {ST_COOLDOWN,      EV_DRAIN_REQUESTED}:  r.to = ST_DRAINING;
            {ST_DRAINING,      EV_DRAIN_COMPLETE}:   r.to = ST_SHUTTING_DOWN;
            {ST_SHUTTING_DOWN, EV_SHUTDOWN_DONE}:    r.to = ST_SHUTDOWN;
            {ST_FAULTED,       EV_RESET}:            r.to = ST_UNINITIALIZED;
            {ST_SHUTDOWN,      EV_RESET}:            r.to = ST_UNINITIALIZED;
            default:                                 r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lesm_if.sv
`default_nettype none

interface lesm_req_if;
    logic                  valid;
    logic                  ready;
    lesm_pkg::req_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lesm_rsp_if;
    logic                  valid;
    logic                  ready;
    lesm_pkg::rsp_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lesm_bin_unit.sv
`default_nettype none

module lesm_bin_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lesm_pkg::bin_req_t            rd,
    input  wire logic                          advance,
    output logic [lesm_pkg::BIN_W-1:0]         total
);
    import lesm_pkg::*;

    logic [BIN_W-1:0]   mem [NUM_STATES];
    logic [NUM_STATES-1:0] written_reg;

    logic [BIN_W-1:0]   rdata_reg;
    logic               rvalid_reg;
    logic [STATE_W-1:0] addr_reg;
    logic               add_en_reg;
    logic [TICK_W-1:0]  add_val_reg;
    logic               fwd_hit_reg;
    logic [BIN_W-1:0]   fwd_data_reg;

    logic [BIN_W-1:0]   base;
    logic               wr_en;

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            base = fwd_data_reg;
        end
        else if (rvalid_reg)
        begin
            base = rdata_reg;
        end
        else
        begin
            base = '0;
        end
        total = base + (add_en_reg ? {{(BIN_W-TICK_W){1'b0}}, add_val_reg} : '0);
    end

    assign wr_en = advance && add_en_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= total;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    // Capture the read together with any write to the same bin on that edge.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            addr_reg     <= rd.addr;
            add_val_reg  <= rd.add_val;
            fwd_data_reg <= total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
            add_en_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[addr_reg] <= 1'b1;
            end
            if (rd.en)
            begin
                rvalid_reg  <= written_reg[rd.addr];
                add_en_reg  <= rd.add_en;
                fwd_hit_reg <= wr_en && (addr_reg == rd.addr);
            end
            else if (wr_en)
            begin
                // Drop the add once written so a stalled entry never adds twice.
                add_en_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> written_reg[$past(addr_reg)])
        else $error("bin written but not marked");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd.en && wr_en && (addr_reg == rd.addr) |=> fwd_hit_reg)
        else $error("missed forward of same-bin write");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd.en |=> !add_en_reg)
        else $error("pending add survived its write");

endmodule

`default_nettype wire

FILE: rtl/core/lifecycle_event_state_machine_top.sv
`default_nettype none

// Lifecycle event state machine.
// req carries one beat per item: an event (req_type 0) matched against the built-in
// rule table, or a forced state (req_type 1), each with a tick time stamp.
// rsp returns exactly one beat per req beat, in order: the old and new state,
// residency, sequence number, all counters after the item and the residency bin
// of the old state after the item.
// A req beat is registered in the bin stage and then in the output register that drives rsp. The state,
// counters and rule decode finish in the accept cycle; the per-state bin lives in
// a synchronous memory and its read-add-write completes in the bin stage,
// with a same-bin write forwarded to the read that follows it.
// Throughput: one beat per cycle sustained while rsp.ready stays high.
// When rsp stalls, the output register and the bin stage hold two results; req.ready
// drops only when both are full, and no beat is lost or repeated.
// Reset clears the state to Uninitialized, the entry time, every counter and the
// bin valid flags, so every bin reads zero until first written; there is no
// clearing pass.
module lifecycle_event_state_machine_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lesm_req_if.sink    req,
    lesm_rsp_if.source  rsp
);
    import lesm_pkg::*;

    lesm_state_t        state_reg, state_next;
    logic [TICK_W-1:0]  entry_time_reg, entry_time_next;
    logic [CNT_W-1:0]   seq_reg, seq_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   rejected_reg, rejected_next;
    logic [CNT_W-1:0]   fault_reg, fault_next;
    logic [CNT_W-1:0]   recovery_reg, recovery_next;
    logic [CNT_W-1:0]   hotpatch_reg, hotpatch_next;
    logic [TICK_W-1:0]  max_reg, max_next;

    logic               s2_valid_reg;
    rsp_item_t          s2_item_reg, s2_item_next;
    logic               out_valid_reg;
    rsp_item_t          out_item_reg, out_item_next;

    logic               in_acc;
    logic               s2_adv;
    logic               force_ok;
    logic               ev_taken;
    rule_res_t          rule;
    logic [TICK_W-1:0]  res;
    bin_req_t           bin_rd;
    logic [BIN_W-1:0]   bin_total;

    assign s2_adv    = s2_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s2_valid_reg || s2_adv;
    assign in_acc    = req.valid && req.ready;

    assign rule     = rule_lookup(state_reg, req.data.event_code);
    assign res      = req.data.now_ticks - entry_time_reg;
    assign force_ok = (req.data.req_type == REQ_FORCE)
                      && (req.data.forced_state < STATE_W'(NUM_STATES));
    assign ev_taken = (req.data.req_type == REQ_EVENT) && rule.hit;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (in_acc)
        begin
            priority if (force_ok)
            begin
                state_next = lesm_state_t'(req.data.forced_state);
            end
            else if (ev_taken)
            begin
                state_next = rule.to;
            end
        end
    end

    // Counters and time stamps
    always_comb
    begin
        entry_time_next = entry_time_reg;
        seq_next        = seq_reg;
        total_next      = total_reg;
        rejected_next   = rejected_reg;
        fault_next      = fault_reg;
        recovery_next   = recovery_reg;
        hotpatch_next   = hotpatch_reg;
        max_next        = max_reg;
        if (in_acc)
        begin
            seq_next = seq_reg + 1'b1;
            if (force_ok || ev_taken)
            begin
                entry_time_next = req.data.now_ticks;
            end
            if ((req.data.req_type == REQ_EVENT) && !rule.hit)
            begin
                rejected_next = rejected_reg + 1'b1;
            end
            if (ev_taken)
            begin
                total_next = total_reg + 1'b1;
                if (rule.to == ST_FAULTED)
                begin
                    fault_next = fault_reg + 1'b1;
                end
                if ((state_reg == ST_RECOVERING) && (rule.to == ST_READY))
                begin
                    recovery_next = recovery_reg + 1'b1;
                end
                if (rule.to == ST_HOTPATCH)
                begin
                    hotpatch_next = hotpatch_reg + 1'b1;
                end
                if (res > max_reg)
                begin
                    max_next = res;
                end
            end
        end
    end

    always_comb
    begin
        s2_item_next.accepted        = force_ok || ev_taken;
        s2_item_next.old_state       = state_reg;
        s2_item_next.new_state       = state_next;
        s2_item_next.residency_ticks = res;
        s2_item_next.sequence_number = seq_reg;
        s2_item_next.total_count     = total_next;
        s2_item_next.rejected_count  = rejected_next;
        s2_item_next.fault_count     = fault_next;
        s2_item_next.recovery_count  = recovery_next;
        s2_item_next.hotpatch_count  = hotpatch_next;
        s2_item_next.max_residency   = max_next;
        s2_item_next.old_state_total = '0;

        bin_rd.en      = in_acc;
        bin_rd.addr    = state_reg;
        bin_rd.add_en  = ev_taken;
        bin_rd.add_val = res;
    end

    lesm_bin_unit u_bins (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (bin_rd),
        .advance (s2_adv),
        .total   (bin_total)
    );

    always_comb
    begin
        out_item_next                 = s2_item_reg;
        out_item_next.old_state_total = bin_total;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s2_item_reg <= s2_item_next;
        end
        if (s2_adv)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_UNINITIALIZED;
            entry_time_reg <= '0;
            seq_reg        <= '0;
            total_reg      <= '0;
            rejected_reg   <= '0;
            fault_reg      <= '0;
            recovery_reg   <= '0;
            hotpatch_reg   <= '0;
            max_reg        <= '0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            entry_time_reg <= entry_time_next;
            seq_reg        <= seq_next;
            total_reg      <= total_next;
            rejected_reg   <= rejected_next;
            fault_reg      <= fault_next;
            recovery_reg   <= recovery_next;
            hotpatch_reg   <= hotpatch_next;
            max_reg        <= max_next;
            if (in_acc)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_adv |=> s2_valid_reg && $stable(s2_item_reg))
        else $error("bin stage lost a held item");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> seq_reg == $past(seq_reg) + 1'b1)
        else $error("sequence did not advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (req.data.req_type == REQ_EVENT) && !rule.hit
        |=> rejected_reg == $past(rejected_reg) + 1'b1 && state_reg == $past(state_reg))
        else $error("rejected event changed state or missed count");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.accepted |-> rsp.data.old_state == rsp.data.new_state)
        else $error("rejected item moved state");

endmodule

`default_nettype wire

FILE: verif/lesm_lifecycle_checker.sv
`default_nettype none

module lesm_lifecycle_checker
    import lesm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    lesm_req_if          req,
    lesm_rsp_if          rsp,
    output logic [17:0]  legal_events,
    output int unsigned  outstanding,
    output int unsigned  results_checked,
    output int unsigned  error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RULES  = 25;

    typedef struct packed {
        lesm_state_t src;
        lesm_event_t trig;
        lesm_state_t dst;
    } lc_rule_t;

    // Earlier entries win when more than one matches.
    localparam lc_rule_t LIFECYCLE_RULES [NUM_RULES] = '{
        '{ST_UNINITIALIZED, EV_INITIALIZE,       ST_INITIALIZING},
        '{ST_INITIALIZING,  EV_MODEL_LOADED,     ST_MODEL_LOADING},
        '{ST_MODEL_LOADING, EV_MODEL_LOADED,     ST_READY},
        '{ST_READY,         EV_REQUEST_RECEIVED, ST_PREFETCHING},
        '{ST_PREFETCHING,   EV_PREFETCH_DONE,    ST_COMPUTING},
        '{ST_COMPUTING,     EV_LAYER_COMPUTED,   ST_COMPUTING},
        '{ST_COMPUTING,     EV_FORWARD_DONE,     ST_SAMPLING},
        '{ST_SAMPLING,      EV_TOKEN_SAMPLED,    ST_STREAMING},
        '{ST_STREAMING,     EV_TOKEN_STREAMED,   ST_PREFETCHING},
        '{ST_STREAMING,     EV_GENERATION_DONE,  ST_COOLDOWN},
        '{ST_COOLDOWN,      EV_COOLDOWN_DONE,    ST_READY},
        '{ST_READY,         EV_HOTPATCH_REQUEST, ST_HOTPATCH},
        '{ST_HOTPATCH,      EV_HOTPATCH_APPLIED, ST_READY},
        '{ST_COMPUTING,     EV_FAULT_DETECTED,   ST_FAULTED},
        '{ST_SAMPLING,      EV_FAULT_DETECTED,   ST_FAULTED},
        '{ST_PREFETCHING,   EV_FAULT_DETECTED,   ST_FAULTED},
        '{ST_STREAMING,     EV_FAULT_DETECTED,   ST_FAULTED},
        '{ST_FAULTED,       EV_INITIALIZE,       ST_RECOVERING},
        '{ST_RECOVERING,    EV_RECOVERY_DONE,    ST_READY},
        '{ST_READY,         EV_DRAIN_REQUESTED,  ST_DRAINING},
        '{ST_COOLDOWN,      EV_DRAIN_REQUESTED,  ST_DRAINING},
        '{ST_DRAINING,      EV_DRAIN_COMPLETE,   ST_SHUTTING_DOWN},
        '{ST_SHUTTING_DOWN, EV_SHUTDOWN_DONE,    ST_SHUTDOWN},
        '{ST_FAULTED,       EV_RESET,            ST_UNINITIALIZED},
        '{ST_SHUTDOWN,      EV_RESET,            ST_UNINITIALIZED}
    };

    lesm_state_t          cur_state;
    logic [TICK_W-1:0]    entry_time;
    logic [BIN_W-1:0]     residency_bins [NUM_STATES];
    logic [CNT_W-1:0]     seq_cnt;
    logic [CNT_W-1:0]     total_cnt;
    logic [CNT_W-1:0]     reject_cnt;
    logic [CNT_W-1:0]     fault_cnt;
    logic [CNT_W-1:0]     recover_cnt;
    logic [CNT_W-1:0]     hotpatch_cnt;
    logic [TICK_W-1:0]    max_res;
    rsp_item_t            expected_reports [$];

    always_comb
    begin
        legal_events = '0;
        for (int k = 0; k < NUM_RULES; k++)
        begin
            if (LIFECYCLE_RULES[k].src == cur_state)
                legal_events[LIFECYCLE_RULES[k].trig] = 1'b1;
        end
    end

    task automatic apply_lifecycle_item(input req_item_t it, output rsp_item_t r);
        logic [TICK_W-1:0] res;
        lesm_state_t       nxt;
        logic              hit;
        res = it.now_ticks - entry_time;
        nxt = cur_state;
        hit = 1'b0;
        r = '0;
        r.old_state = cur_state;
        r.sequence_number = seq_cnt;
        seq_cnt = seq_cnt + 1'b1;
        if (it.req_type == REQ_FORCE)
        begin
            // drop a force to a code that names no state
            if (it.forced_state < NUM_STATES)
            begin
                nxt = lesm_state_t'(it.forced_state);
                hit = 1'b1;
                entry_time = it.now_ticks;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_RULES; k++)
            begin
                if (!hit && LIFECYCLE_RULES[k].src == cur_state
                         && LIFECYCLE_RULES[k].trig == it.event_code)
                begin
                    hit = 1'b1;
                    nxt = LIFECYCLE_RULES[k].dst;
                end
            end
            if (!hit)
                reject_cnt = reject_cnt + 1'b1;
            else
            begin
                residency_bins[cur_state] = residency_bins[cur_state] + BIN_W'(res);
                entry_time = it.now_ticks;
                if (nxt == ST_FAULTED)
                    fault_cnt = fault_cnt + 1'b1;
                if (cur_state == ST_RECOVERING && nxt == ST_READY)
                    recover_cnt = recover_cnt + 1'b1;
                if (nxt == ST_HOTPATCH)
                    hotpatch_cnt = hotpatch_cnt + 1'b1;
                total_cnt = total_cnt + 1'b1;
                if (res > max_res)
                    max_res = res;
            end
        end
        r.accepted        = hit;
        r.new_state       = nxt;
        r.residency_ticks = res;
        r.total_count     = total_cnt;
        r.rejected_count  = reject_cnt;
        r.fault_count     = fault_cnt;
        r.recovery_count  = recover_cnt;
        r.hotpatch_count  = hotpatch_cnt;
        r.max_residency   = max_res;
        r.old_state_total = residency_bins[r.old_state];
        cur_state = nxt;
    endtask

    // Append at the tail of the expected queue.
    task automatic enqueue_report(input rsp_item_t r);
        expected_reports = {expected_reports, r};
    endtask

    task automatic check_field(input string name, input logic [BIN_W-1:0] want,
                               input logic [BIN_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        rsp_item_t got;
        if (!rst_n)
        begin
            cur_state    = ST_UNINITIALIZED;
            entry_time   = '0;
            seq_cnt      = '0;
            total_cnt    = '0;
            reject_cnt   = '0;
            fault_cnt    = '0;
            recover_cnt  = '0;
            hotpatch_cnt = '0;
            max_res      = '0;
            for (int k = 0; k < NUM_STATES; k++)
                residency_bins[k] = '0;
            expected_reports.delete();
            outstanding     = 0;
            results_checked = 0;
            error_count     = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (expected_reports.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result beat with nothing expected, actual %0h", $time, got);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("accepted",        want.accepted,        got.accepted);
                    check_field("old_state",       want.old_state,       got.old_state);
                    check_field("new_state",       want.new_state,       got.new_state);
                    check_field("residency_ticks", want.residency_ticks, got.residency_ticks);
                    check_field("sequence_number", want.sequence_number, got.sequence_number);
                    check_field("total_count",     want.total_count,     got.total_count);
                    check_field("rejected_count",  want.rejected_count,  got.rejected_count);
                    check_field("fault_count",     want.fault_count,     got.fault_count);
                    check_field("recovery_count",  want.recovery_count,  got.recovery_count);
                    check_field("hotpatch_count",  want.hotpatch_count,  got.hotpatch_count);
                    check_field("max_residency",   want.max_residency,   got.max_residency);
                    check_field("old_state_total", want.old_state_total, got.old_state_total);
                    results_checked++;
                end
            end
            if (req.valid && req.ready)
            begin
                apply_lifecycle_item(req.data, want);
                enqueue_report(want);
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

`default_nettype wire

FILE: verif/lifecycle_event_state_machine_top_tb.sv
`default_nettype none

module lifecycle_event_state_machine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lesm_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASE_LEN    = 250;
    localparam int LONG_HOLD    = 300;

    logic clk = 1'b0;
    logic rst_n;

    lesm_req_if req_ch ();
    lesm_rsp_if rsp_ch ();

    logic [17:0]  legal_events;
    int unsigned  outstanding;
    int unsigned  results_checked;
    int unsigned  error_count;

    bit           src_idle_en;
    bit           rsp_idle_en;
    bit           long_hold_req;
    int           hold_left;
    logic [31:0]  tick_now;
    int unsigned  n_events;
    int unsigned  n_bad_codes;
    int unsigned  n_forces;
    int unsigned  n_bad_forces;

    always #5 clk = ~clk;

    lifecycle_event_state_machine_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lesm_lifecycle_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .legal_events    (legal_events),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .error_count     (error_count)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic req_item_t event_beat(logic [EVENT_W-1:0] code, logic [TICK_W-1:0] now);
        req_item_t it;
        it.req_type     = REQ_EVENT;
        it.event_code   = code;
        it.forced_state = STATE_W'($urandom_range(0, 15));
        it.now_ticks    = now;
        return it;
    endfunction

    function automatic req_item_t force_beat(logic [STATE_W-1:0] st, logic [TICK_W-1:0] now);
        req_item_t it;
        it.req_type     = REQ_FORCE;
        it.event_code   = EVENT_W'($urandom_range(0, 31));
        it.forced_state = st;
        it.now_ticks    = now;
        return it;
    endfunction

    // Mostly legal events for the current state, with stray codes and forces mixed in.
    function automatic req_item_t random_beat();
        int                 pick;
        int                 k;
        logic [EVENT_W-1:0] code;
        if ($urandom_range(0, 19) == 0)
            tick_now = $urandom();
        else
            tick_now = tick_now + $urandom_range(0, 400);
        pick = $urandom_range(0, 99);
        if (pick < 78)
        begin
            k = $urandom_range(0, $countones(legal_events) - 1);
            code = '0;
            for (int e = 0; e < 18; e++)
            begin
                if (legal_events[e])
                begin
                    if (k == 0)
                        code = EVENT_W'(e);
                    k--;
                end
            end
            return event_beat(code, tick_now);
        end
        if (pick < 88)
            return event_beat(EVENT_W'($urandom_range(0, 31)), tick_now);
        return force_beat(STATE_W'($urandom_range(0, 15)), tick_now);
    endfunction

    task automatic send_beat(input req_item_t it);
        if (it.req_type == REQ_FORCE)
        begin
            n_forces++;
            if (it.forced_state >= NUM_STATES)
                n_bad_forces++;
        end
        else
        begin
            n_events++;
            if (it.event_code > EV_RESET)
                n_bad_codes++;
        end
        req_ch.data  = it;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid = 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else if (rsp_idle_en && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left = gap_len() - 1;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        src_idle_en   = 1'b1;
        rsp_idle_en   = 1'b1;
        long_hold_req = 1'b0;
        tick_now      = '0;
        n_events      = 0;
        n_bad_codes   = 0;
        n_forces      = 0;
        n_bad_forces  = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk a path through every state, with time stamps at both extremes.
        send_beat(event_beat(5'd31, 32'h0000_0000));
        send_beat(force_beat(4'd15, 32'hFFFF_FFFF));
        send_beat(event_beat(EV_INITIALIZE, 32'h0000_0005));
        send_beat(event_beat(EV_MODEL_LOADED, 32'h0000_0100));
        send_beat(event_beat(EV_MODEL_LOADED, 32'h0001_0000));
        send_beat(event_beat(EV_REQUEST_RECEIVED, 32'h0001_0007));
        send_beat(event_beat(EV_PREFETCH_DONE, 32'h0002_0000));
        send_beat(event_beat(EV_LAYER_COMPUTED, 32'h0002_0010));
        send_beat(event_beat(EV_FORWARD_DONE, 32'h8000_0000));
        send_beat(event_beat(EV_TOKEN_SAMPLED, 32'h8000_0001));
        send_beat(event_beat(EV_TOKEN_STREAMED, 32'h8000_0100));
        send_beat(event_beat(EV_FAULT_DETECTED, 32'h8000_0200));
        send_beat(event_beat(EV_INITIALIZE, 32'h8000_0300));
        send_beat(event_beat(EV_RECOVERY_DONE, 32'h8000_0400));
        send_beat(event_beat(EV_HOTPATCH_REQUEST, 32'h8000_0500));
        send_beat(event_beat(EV_HOTPATCH_APPLIED, 32'h8000_0600));
        send_beat(event_beat(EV_DRAIN_REQUESTED, 32'h8000_0700));
        send_beat(event_beat(EV_DRAIN_COMPLETE, 32'h8000_0800));
        send_beat(event_beat(EV_SHUTDOWN_DONE, 32'h8000_0900));
        send_beat(event_beat(EV_RESET, 32'h8000_0A00));
        send_beat(force_beat(ST_STREAMING, 32'h0000_0000));
        send_beat(event_beat(EV_GENERATION_DONE, 32'hFFFF_FFFF));
        send_beat(event_beat(EV_COOLDOWN_DONE, 32'h0000_0003));
        send_beat(force_beat(ST_FAULTED, 32'h0000_0010));
        send_beat(event_beat(EV_RESET, 32'h0000_0020));
        tick_now = 32'h0000_0020;
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                case (i / PHASE_LEN)
                    0:
                    begin
                        src_idle_en = 1'b1;
                        rsp_idle_en = 1'b1;
                    end
                    1:
                    begin
                        // back-to-back input against a long output hold: fills the block
                        src_idle_en = 1'b0;
                        rsp_idle_en = 1'b0;
                        long_hold_req = 1'b1;
                    end
                    2:
                    begin
                        drain_results();
                        src_idle_en = 1'b1;
                        rsp_idle_en = 1'b0;
                    end
                    default:
                    begin
                        src_idle_en = 1'b0;
                        rsp_idle_en = 1'b1;
                        long_hold_req = 1'b1;
                    end
                endcase
            end
            send_beat(random_beat());
        end

        req_ch.valid = 1'b0;
        wait (outstanding == 0);
        repeat (10) @(negedge clk);

        $display("Sent %0d beats: %0d events (%0d with undefined codes), %0d forces (%0d to no state).",
                 n_events + n_forces, n_events, n_bad_codes, n_forces, n_bad_forces);
        $display("Checked %0d results over idle, idle-free and long back-pressure phases.",
                 results_checked);
        if (error_count == 0)
            $display("lifecycle_event_state_machine_top_tb: done, clean");
        else
            $display("lifecycle_event_state_machine_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", outstanding);
        $display("lifecycle_event_state_machine_top_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
